### rtl/moving_average_cold_start_macros.svh
// assertion helpers for the moving average block
// both expect clk_i and rst_ni in the scope of the use
`ifndef MOVING_AVERAGE_COLD_START_MACROS_SVH
`define MOVING_AVERAGE_COLD_START_MACROS_SVH

`ifndef SYNTHESIS
`define MAVG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MAVG_ASSERT_NEVER(name, cond, msg) \
  `MAVG_ASSERT(name, !(cond), msg)
`else
`define MAVG_ASSERT(name, prop, msg)
`define MAVG_ASSERT_NEVER(name, cond, msg)
`endif

`endif

### rtl/mavg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  localparam int unsigned DATA_W     = 24;
  localparam int unsigned CH_IN_W    = 2;
  localparam int unsigned NUM_THRESH = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [CH_IN_W-1:0]       chan_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_TEMP  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_HUMI  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_LIGHT = cfg_idx_t'(2);

  // threshold reset values, q20.4
  localparam sample_t THR_TEMP_RST  = sample_t'(-1600);
  localparam sample_t THR_HUMI_RST  = sample_t'(-1600);
  localparam sample_t THR_LIGHT_RST = sample_t'(0);

  // offset of 2^23 in the sample domain is a flip of the sign bit
  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

### rtl/mavg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mavg_in_if import mavg_pkg::*;;
  logic    valid;
  logic    ready;
  chan_t   channel;
  sample_t sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mavg_out_if import mavg_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t mean;
  logic    accepted;

  modport source (output valid, output mean, output accepted, input ready);
  modport sink   (input valid, input mean, input accepted, output ready);
endinterface

`default_nettype wire

### rtl/mavg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mavg_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 24
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/moving_average_cold_start.sv
// result path: stage 1, 2 and 3 registers, then the output register
// throughput: one item per cycle; the window ram has one read and one write per cycle
// stalls only when the output register holds a result that is not taken
// reset: thresholds return to defaults, every channel is empty, pipeline flushed
// no clearing pass: window entries are tracked by a per-channel fill count
`timescale 1ns / 1ps
`default_nettype none
`include "moving_average_cold_start_macros.svh"

module moving_average_cold_start import mavg_pkg::*; #(
  parameter int unsigned WINDOW   = 8,
  parameter int unsigned CHANNELS = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mavg_in_if.sink  in_i,
  mavg_out_if.source out_o,
  input  logic     cfg_we_i,
  input  cfg_idx_t cfg_idx_i,
  input  sample_t  cfg_data_i
);

  localparam int unsigned WP_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DEPTH = CHANNELS * WINDOW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = DATA_W + $clog2(WINDOW);
  // floor(2^SW / WINDOW), estimate is low by at most one
  localparam logic [SW-1:0] MRECIP = SW'((64'd1 << SW) / WINDOW);

  typedef struct packed {
    logic [CH_W-1:0] idx;
    sample_t         sample;
    logic            valid;
    logic            cold;
    logic            has_mean;
    logic            use_fill;
    sample_t         fillv;
  } s1_t;

  typedef struct packed {
    logic [SW-1:0] u;
    logic          has_mean;
    logic          acc;
  } s2_t;

  typedef struct packed {
    logic [DATA_W-1:0] q;
    logic [SW-1:0]     u;
    logic              has_mean;
    logic              acc;
  } s3_t;

  sample_t         thr_q [NUM_THRESH];
  logic            filled_q [CHANNELS];
  logic [WP_W-1:0] wp_q [CHANNELS];
  logic [CNT_W-1:0] wcnt_q [CHANNELS];
  sample_t         fillv_q [CHANNELS];
  // running sums are kept offset by WINDOW * 2^23 so they never go negative
  logic [SW-1:0]   sumb_q [CHANNELS];

  logic s1v_q, s2v_q, s3v_q, ov_q;
  s1_t  s1_q;
  s2_t  s2_q;
  s3_t  s3_q;
  sample_t out_mean_q;
  logic    out_acc_q;

  logic out_free, r3, r2, r1, acc_in;

  // ---------------- input decode ----------------
  logic [CH_W+CH_IN_W-1:0] ch_ext;
  logic            served;
  logic [CH_W-1:0] idx;
  chan_t           thr_idx;
  sample_t         thr;
  logic            valid, cold, upd, use_fill, has_mean;
  logic [AW-1:0]   ram_addr;
  sample_t         ram_rdata;

  always_comb begin
    ch_ext   = {{CH_W{1'b0}}, in_i.channel};
    served   = (ch_ext < (CH_W + CH_IN_W)'(CHANNELS)) &&
               (in_i.channel < CH_IN_W'(NUM_THRESH));
    idx      = served ? ch_ext[CH_W-1:0] : '0;
    thr_idx  = served ? in_i.channel : '0;
    thr      = thr_q[thr_idx];
    valid    = served && !($signed(in_i.sample) < $signed(thr));
    cold     = valid && !filled_q[idx];
    upd      = valid && filled_q[idx];
    use_fill = wcnt_q[idx] < CNT_W'(WINDOW);
    has_mean = served && (filled_q[idx] || valid);
    ram_addr = AW'(idx * WINDOW) + AW'(wp_q[idx]);
  end

  assign out_free = !ov_q || out_o.ready;
  assign r3       = !s3v_q || out_free;
  assign r2       = !s2v_q || r3;
  assign r1       = !s1v_q || r2;
  assign in_i.ready = r1;
  assign acc_in   = in_i.valid && r1;

  mavg_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_window (
    .clk_i    (clk_i),
    .wr_en_i  (acc_in && upd),
    .wr_addr_i(ram_addr),
    .wr_data_i(in_i.sample),
    .rd_en_i  (acc_in),
    .rd_addr_i(ram_addr),
    .rd_data_o(ram_rdata)
  );

  // thresholds and per-channel control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q[REG_TEMP]  <= THR_TEMP_RST;
      thr_q[REG_HUMI]  <= THR_HUMI_RST;
      thr_q[REG_LIGHT] <= THR_LIGHT_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        filled_q[c] <= 1'b0;
        wp_q[c]     <= '0;
        wcnt_q[c]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TEMP:  thr_q[REG_TEMP]  <= cfg_data_i;
          REG_HUMI:  thr_q[REG_HUMI]  <= cfg_data_i;
          REG_LIGHT: thr_q[REG_LIGHT] <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc_in && cold) begin
        filled_q[idx] <= 1'b1;
        wcnt_q[idx]   <= '0;
      end
      if (acc_in && upd) begin
        wp_q[idx] <= (wp_q[idx] == WP_W'(WINDOW - 1)) ? '0 : wp_q[idx] + 1'b1;
        if (use_fill) begin
          wcnt_q[idx] <= wcnt_q[idx] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && cold) begin
      fillv_q[idx] <= in_i.sample;
    end
  end

  // ---------------- stage 1: running sum ----------------
  sample_t       old_val;
  logic [SW-1:0] sb_ext, cold_sum, upd_sum, new_sumb;

  always_comb begin
    old_val  = s1_q.use_fill ? s1_q.fillv : ram_rdata;
    sb_ext   = SW'({~s1_q.sample[DATA_W-1], s1_q.sample[DATA_W-2:0]});
    cold_sum = SW'(sb_ext * WINDOW);
    upd_sum  = sumb_q[s1_q.idx]
             - {{(SW-DATA_W){old_val[DATA_W-1]}}, old_val}
             + {{(SW-DATA_W){s1_q.sample[DATA_W-1]}}, s1_q.sample};
    if (s1_q.cold) begin
      new_sumb = cold_sum;
    end else if (s1_q.valid) begin
      new_sumb = upd_sum;
    end else begin
      new_sumb = sumb_q[s1_q.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1v_q && r2 && s1_q.valid) begin
      sumb_q[s1_q.idx] <= new_sumb;
    end
  end

  // ---------------- stage 2: reciprocal multiply ----------------
  logic [2*SW-1:0] prod;
  assign prod = {{SW{1'b0}}, s2_q.u} * {{SW{1'b0}}, MRECIP};

  // ---------------- stage 3: quotient correction ----------------
  logic [SW-1:0]     rem;
  logic [DATA_W-1:0] q_fix;
  sample_t           mean_d;

  always_comb begin
    rem    = s3_q.u - SW'(s3_q.q * WINDOW);
    q_fix  = s3_q.q + DATA_W'(rem >= SW'(WINDOW));
    mean_d = s3_q.has_mean ? sample_t'(q_fix ^ SIGN_FLIP) : '0;
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
      s3v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (r1) begin
        s1v_q <= in_i.valid;
      end
      if (r2) begin
        s2v_q <= s1v_q;
      end
      if (r3) begin
        s3v_q <= s2v_q;
      end
      if (out_free) begin
        ov_q <= s3v_q;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_q.idx      <= idx;
      s1_q.sample   <= in_i.sample;
      s1_q.valid    <= valid;
      s1_q.cold     <= cold;
      s1_q.has_mean <= has_mean;
      s1_q.use_fill <= use_fill;
      s1_q.fillv    <= fillv_q[idx];
    end
    if (r2 && s1v_q) begin
      s2_q.u        <= new_sumb;
      s2_q.has_mean <= s1_q.has_mean;
      s2_q.acc      <= s1_q.valid;
    end
    if (r3 && s2v_q) begin
      s3_q.q        <= prod[SW +: DATA_W];
      s3_q.u        <= s2_q.u;
      s3_q.has_mean <= s2_q.has_mean;
      s3_q.acc      <= s2_q.acc;
    end
    if (out_free && s3v_q) begin
      out_mean_q <= mean_d;
      out_acc_q  <= s3_q.acc;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.mean     = out_mean_q;
  assign out_o.accepted = out_acc_q;

  `MAVG_ASSERT(a_cold_sets_filled, acc_in && cold |=> filled_q[s1_q.idx], "cold start did not mark channel filled")
  `MAVG_ASSERT(a_out_from_s3, $rose(ov_q) |-> $past(s3v_q), "result appeared without a stage 3 item")
  `MAVG_ASSERT_NEVER(a_acc_without_mean, s2v_q && s2_q.acc && !s2_q.has_mean, "accepted item without a mean")
  `MAVG_ASSERT_NEVER(a_wcnt_range, wcnt_q[idx] > CNT_W'(WINDOW), "fill count beyond window")

endmodule

`default_nettype wire

### bench/mavg_window_checker.sv
`timescale 1ns / 1ps

module mavg_window_checker import mavg_pkg::*; #(
  parameter int unsigned WINDOW   = 8,
  parameter int unsigned CHANNELS = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  chan_t    in_channel_i,
  input  sample_t  in_sample_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  sample_t  out_mean_i,
  input  logic     out_accepted_i,
  input  logic     cfg_we_i,
  input  cfg_idx_t cfg_idx_i,
  input  sample_t  cfg_data_i,
  output int       errors_o,
  output int       pending_o
);

  localparam int unsigned SHIFT = $clog2(WINDOW);

  typedef logic signed [DATA_W+SHIFT-1:0] sum_t;
  typedef struct packed {
    sample_t mean;
    logic    accepted;
  } result_t;

  sample_t     thresh    [NUM_THRESH];
  sample_t     ring      [CHANNELS][WINDOW];
  int unsigned ring_pos  [CHANNELS];
  sum_t        ring_sum  [CHANNELS];
  logic        ring_full [CHANNELS];
  result_t     results_due [$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors_o++;
  endtask

  // one sample through the window of its channel
  task automatic average_sample(input chan_t ch, input sample_t s, output result_t r);
    int c;
    int unsigned p;
    r = '0;
    if (ch >= CHANNELS || ch >= NUM_THRESH) return;
    c = int'(ch);
    if (s < thresh[c]) begin
      if (ring_full[c]) r.mean = sample_t'(ring_sum[c] >>> SHIFT);
    end else if (!ring_full[c]) begin
      // cold start: whole window takes the first valid sample
      for (int i = 0; i < WINDOW; i++) ring[c][i] = s;
      ring_sum[c]  = sum_t'(s) <<< SHIFT;
      ring_full[c] = 1'b1;
      r.mean       = s;
      r.accepted   = 1'b1;
    end else begin
      p = ring_pos[c];
      ring_sum[c] = ring_sum[c] - sum_t'(ring[c][p]) + sum_t'(s);
      ring[c][p]  = s;
      ring_pos[c] = (p + 1) % WINDOW;
      r.mean      = sample_t'(ring_sum[c] >>> SHIFT);
      r.accepted  = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      thresh[REG_TEMP]  = THR_TEMP_RST;
      thresh[REG_HUMI]  = THR_HUMI_RST;
      thresh[REG_LIGHT] = THR_LIGHT_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        ring_pos[c]  = 0;
        ring_sum[c]  = '0;
        ring_full[c] = 1'b0;
        for (int i = 0; i < WINDOW; i++) ring[c][i] = '0;
      end
      results_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result mean %0d accepted %0d with no item waiting",
                                    out_mean_i, out_accepted_i));
        end else begin
          want = results_due.pop_front();
          if (out_mean_i !== want.mean)
            report_mismatch($sformatf("mean %0d, expected %0d", out_mean_i, want.mean));
          if (out_accepted_i !== want.accepted)
            report_mismatch($sformatf("accepted %0b, expected %0b",
                                      out_accepted_i, want.accepted));
        end
      end
      if (cfg_we_i && cfg_idx_i < NUM_THRESH) thresh[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        average_sample(in_channel_i, in_sample_i, want);
        results_due.push_back(want);
      end
    end
    pending_o = results_due.size();
  end

endmodule

### bench/moving_average_cold_start_tb.sv
`timescale 1ns / 1ps

module moving_average_cold_start_tb;
  import mavg_pkg::*;

  localparam chan_t    CH_TEMP   = chan_t'(0);
  localparam chan_t    CH_HUMI   = chan_t'(1);
  localparam chan_t    CH_LIGHT  = chan_t'(2);
  localparam chan_t    CH_UNUSED = chan_t'(3);
  localparam cfg_idx_t REG_NONE  = cfg_idx_t'(3);
  localparam int       LATENCY   = 3;
  localparam int       S_MIN     = -8388608;
  localparam int       S_MAX     = 8388607;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  sample_t  cfg_data;
  int       errors;
  int       pending;
  bit       idle_on = 1'b1;
  sample_t  thr_set [NUM_THRESH];

  mavg_in_if  in_ch ();
  mavg_out_if out_ch ();

  moving_average_cold_start dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mavg_window_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_channel_i   (in_ch.channel),
    .in_sample_i    (in_ch.sample),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_mean_i     (out_ch.mean),
    .out_accepted_i (out_ch.accepted),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("moving_average_cold_start_tb: done, errors");
    $finish;
  end

  // result side stalls in bursts while idle_on is set
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // called right after a rising edge; returns right after the edge that takes the item
  task automatic send_sample(input chan_t ch, input sample_t s);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.channel <= ch;
    in_ch.sample  <= s;
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (LATENCY + 1) @(posedge clk_i);
  endtask

  task automatic write_threshold(input cfg_idx_t idx, input sample_t value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    if (idx < NUM_THRESH) thr_set[idx] = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic sample_t pick_sample(input chan_t ch);
    int unsigned mode;
    int t;
    mode = $urandom_range(0, 9);
    if (mode < 4) return sample_t'($urandom);
    if (mode < 7 && ch < NUM_THRESH) begin
      // around the threshold, equal included
      t = int'(thr_set[ch]) + int'($urandom_range(0, 8)) - 4;
      if (t < S_MIN) t = S_MIN;
      if (t > S_MAX) t = S_MAX;
      return sample_t'(t);
    end
    return sample_t'(int'($urandom_range(0, 8000)) - 4000);
  endfunction

  task automatic run_items(input int n);
    chan_t ch;
    repeat (n) begin
      ch = ($urandom_range(0, 15) == 0) ? CH_UNUSED : chan_t'($urandom_range(0, 2));
      send_sample(ch, pick_sample(ch));
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.channel <= CH_TEMP;
    in_ch.sample  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_TEMP;
    cfg_data      <= '0;
    thr_set[REG_TEMP]  = THR_TEMP_RST;
    thr_set[REG_HUMI]  = THR_HUMI_RST;
    thr_set[REG_LIGHT] = THR_LIGHT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty channels, below threshold and unserved channel
    send_sample(CH_UNUSED, sample_t'(0));
    send_sample(CH_TEMP, sample_t'(-1601));
    send_sample(CH_LIGHT, sample_t'(-1));
    // cold starts, two at the threshold exactly
    send_sample(CH_TEMP, sample_t'(-1600));
    send_sample(CH_HUMI, sample_t'(S_MAX));
    send_sample(CH_LIGHT, sample_t'(0));
    // invalid samples on filled channels and on the unserved channel
    send_sample(CH_HUMI, sample_t'(S_MIN));
    send_sample(CH_LIGHT, sample_t'(-1));
    send_sample(CH_UNUSED, sample_t'(S_MIN));
    // wrap the temperature ring with negative sums
    send_sample(CH_TEMP, sample_t'(-1));
    send_sample(CH_TEMP, sample_t'(-2));
    send_sample(CH_TEMP, sample_t'(-3));
    send_sample(CH_TEMP, sample_t'(-5));
    send_sample(CH_TEMP, sample_t'(-7));
    send_sample(CH_TEMP, sample_t'(-11));
    send_sample(CH_TEMP, sample_t'(-13));
    send_sample(CH_TEMP, sample_t'(-17));
    send_sample(CH_TEMP, sample_t'(S_MAX));
    drain();
    write_threshold(REG_NONE, sample_t'(S_MAX));
    write_threshold(REG_TEMP, sample_t'(S_MIN));
    send_sample(CH_TEMP, sample_t'(S_MIN));
    send_sample(CH_TEMP, sample_t'(S_MIN));
    send_sample(CH_HUMI, sample_t'(S_MAX));
    send_sample(CH_UNUSED, sample_t'(S_MAX));
    drain();

    // random phases, thresholds changed only while idle
    write_threshold(REG_TEMP, THR_TEMP_RST);
    run_items(200);
    drain();
    write_threshold(REG_TEMP, sample_t'(S_MIN));
    write_threshold(REG_HUMI, sample_t'(S_MAX));
    write_threshold(REG_LIGHT, sample_t'($urandom));
    run_items(100);
    drain();
    run_items(100);
    drain();
    write_threshold(REG_TEMP, sample_t'($urandom));
    write_threshold(REG_HUMI, sample_t'($urandom));
    write_threshold(REG_LIGHT, sample_t'(S_MIN));
    write_threshold(REG_NONE, sample_t'($urandom));
    run_items(200);
    drain();
    write_threshold(REG_TEMP, sample_t'(int'($urandom_range(0, 4000)) - 2000));
    write_threshold(REG_HUMI, THR_HUMI_RST);
    write_threshold(REG_LIGHT, THR_LIGHT_RST);
    idle_on = 1'b0;
    run_items(200);
    drain();

    repeat (LATENCY + 5) @(posedge clk_i);
    if (errors == 0) begin
      $display("moving_average_cold_start_tb: done, clean");
    end else begin
      $display("moving_average_cold_start_tb: done, errors");
    end
    $finish;
  end

endmodule
